FILE: design/region_table_fault_checker_defines.svh
// ----------------------------------------------------------------------------
// region_table_fault_checker_defines
// Assertion macros used by the region table top level.
// ----------------------------------------------------------------------------
`ifndef REGION_TABLE_FAULT_CHECKER_DEFINES_SVH
`define REGION_TABLE_FAULT_CHECKER_DEFINES_SVH

// checked while out of reset
`define RTFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RTFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/rtfc_pkg.sv
// ----------------------------------------------------------------------------
// rtfc_pkg
// Types and constants of the region table fault checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtfc_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BITS   = 12;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int ADDR_W      = 32;
  localparam int FLAG_W      = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DENIED = 2'd1,
    ST_FULL   = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  // fault code values
  localparam logic [1:0] CODE_READ_ABSENT  = 2'd0;
  localparam logic [1:0] CODE_READ_PRESENT = 2'd1;

  // flag bits
  localparam int FLAG_READ  = 0;
  localparam int FLAG_WRITE = 1;
  localparam int FLAG_EXEC  = 2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   region_end;
    logic [FLAG_W-1:0]   region_flags;
    logic [1:0]          fault_code;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ADDR_W-1:0]   page_address;
    logic [1:0]          page_perm;
  } rsp_t;

  // handed from one cell to the next
  typedef struct packed {
    logic                k;       // valid and start <= address
    logic                above;   // valid and end > address
    logic                valid;
    logic [ADDR_W-1:0]   start;
    logic [ADDR_W-1:0]   stop;
    logic [FLAG_W-1:0]   flags;
  } link_t;

  // per-cell status toward the top level
  typedef struct packed {
    logic                bad;     // insert would overlap this region
    logic                hit;     // first region ending above the address
    logic                late;    // hit, but region starts above the address
    logic [FLAG_W-1:0]   flags;   // flags when hit, else zero
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: design/rtfc_cell.sv
// ----------------------------------------------------------------------------
// rtfc_cell
// One table slot: holds a region, compares it against the request and
// shifts up from its lower neighbor on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module rtfc_cell (
  input  wire logic                        clk,
  input  wire logic                        valid,
  input  wire logic                        shift_en,
  input  wire logic [rtfc_pkg::ADDR_W-1:0] address,
  input  wire logic [rtfc_pkg::ADDR_W-1:0] region_end,
  input  wire logic [rtfc_pkg::FLAG_W-1:0] region_flags,
  input  wire rtfc_pkg::link_t             prev,
  output rtfc_pkg::link_t                  link,
  output rtfc_pkg::cell_stat_t             stat
);

  logic [rtfc_pkg::ADDR_W-1:0] start;
  logic [rtfc_pkg::ADDR_W-1:0] stop;
  logic [rtfc_pkg::FLAG_W-1:0] flags;
  logic                        k;
  logic                        above;

  assign k     = valid && (start <= address);
  assign above = valid && (stop > address);

  always_comb begin
    link.k     = k;
    link.above = above;
    link.valid = valid;
    link.start = start;
    link.stop  = stop;
    link.flags = flags;
    // ends are sorted too, so any overlap shows at the neighbor slots
    stat.bad   = valid && (k ? (stop > address) : (start < region_end));
    stat.hit   = above && !prev.above;
    stat.late  = stat.hit && (start > address);
    stat.flags = stat.hit ? flags : '0;
  end

  // slots at or after the insert position move up by one
  always_ff @(posedge clk) begin
    if (shift_en && !k) begin
      if (prev.k) begin
        start <= address;
        stop  <= region_end;
        flags <= region_flags;
      end else begin
        start <= prev.start;
        stop  <= prev.stop;
        flags <= prev.flags;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/region_table_fault_checker.sv
// ----------------------------------------------------------------------------
// region_table_fault_checker
// Sorted table of address regions with insert, fault check and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid/req_stall, results leave on
//   rsp/rsp_valid/rsp_stall; a transfer happens when valid is high and
//   stall is low. Every request gives exactly one result.
//   The result is registered at the edge that takes the request. One
//   request per cycle is sustained while no stalled result waits; all table
//   slots compare in parallel and shift by one on insert at that same edge.
//   The slowest path is a 32-bit compare in each slot plus the OR tree
//   across MAX_REGIONS slots.
//   While the result register is full and rsp_stall is high, req_stall is
//   high and the table holds still.
//   Reset empties the table (region count to zero) and drops any pending
//   result; no clearing pass is needed, the table is usable at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "region_table_fault_checker_defines.svh"

module region_table_fault_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rtfc_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rtfc_pkg::rsp_t      rsp
);

  localparam int N = rtfc_pkg::MAX_REGIONS;

  logic [rtfc_pkg::CNT_W-1:0]  region_count;
  logic [rtfc_pkg::CNT_W-1:0]  region_count_next;
  rtfc_pkg::link_t             links [N+1];
  rtfc_pkg::cell_stat_t        stats [N];
  logic [N-1:0]                bad_vec;
  logic [N-1:0]                hit_vec;
  logic [N-1:0]                late_vec;
  logic [rtfc_pkg::FLAG_W-1:0] hit_flags;
  logic                        fire;
  logic                        shift_en;
  logic                        allow;
  rtfc_pkg::rsp_t              rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign fire      = req_valid && !req_stall;

  // slot zero sees a neighbor that always lies below the new start
  always_comb begin
    links[0]       = '0;
    links[0].k     = 1'b1;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rtfc_cell u_cell (
      .clk          (clk),
      .valid        (region_count > rtfc_pkg::CNT_W'(i)),
      .shift_en     (shift_en),
      .address      (req.address),
      .region_end   (req.region_end),
      .region_flags (req.region_flags),
      .prev         (links[i]),
      .link         (links[i+1]),
      .stat         (stats[i])
    );
    assign bad_vec[i]  = stats[i].bad;
    assign hit_vec[i]  = stats[i].hit;
    assign late_vec[i] = stats[i].late;
  end

  always_comb begin
    hit_flags = '0;
    for (int i = 0; i < N; i++) begin
      hit_flags = hit_flags | stats[i].flags;
    end
  end

  always_comb begin
    unique case (req.fault_code)
      rtfc_pkg::CODE_READ_ABSENT:
        allow = hit_flags[rtfc_pkg::FLAG_READ] || hit_flags[rtfc_pkg::FLAG_EXEC];
      rtfc_pkg::CODE_READ_PRESENT: allow = 1'b0;
      default:                     allow = hit_flags[rtfc_pkg::FLAG_WRITE];
    endcase
  end

  always_comb begin
    rsp_next          = '0;
    rsp_next.status   = rtfc_pkg::ST_DENIED;
    region_count_next = region_count;
    shift_en          = 1'b0;
    unique case (rtfc_pkg::op_t'(req.operation))
      rtfc_pkg::OP_INSERT: begin
        priority if (req.address >= req.region_end) begin
          rsp_next.status = rtfc_pkg::ST_BAD;
        end else if (region_count == rtfc_pkg::CNT_W'(N)) begin
          rsp_next.status = rtfc_pkg::ST_FULL;
        end else if (|bad_vec) begin
          rsp_next.status = rtfc_pkg::ST_BAD;
        end else begin
          rsp_next.status   = rtfc_pkg::ST_OK;
          shift_en          = fire;
          region_count_next = region_count + 1'b1;
        end
      end
      rtfc_pkg::OP_CHECK: begin
        if ((|hit_vec) && !(|late_vec) && allow) begin
          rsp_next.status       = rtfc_pkg::ST_OK;
          rsp_next.page_address = {req.address[rtfc_pkg::ADDR_W-1:rtfc_pkg::PAGE_BITS],
                                   rtfc_pkg::PAGE_BITS'(0)};
          rsp_next.page_perm    = {hit_flags[rtfc_pkg::FLAG_WRITE], 1'b1};
        end
      end
      rtfc_pkg::OP_CLEAR: begin
        rsp_next.status   = rtfc_pkg::ST_OK;
        region_count_next = '0;
      end
      default: begin
        rsp_next.status = rtfc_pkg::ST_DENIED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (fire) begin
        region_count <= region_count_next;
        rsp_valid    <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  `RTFC_ASSERT(a_count_range, region_count <= rtfc_pkg::CNT_W'(N), "region count above table size")
  `RTFC_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one region selected")
  `RTFC_ASSERT(a_clear_empties, fire && (req.operation == rtfc_pkg::OP_CLEAR) |=> region_count == '0, "clear left regions")
  `RTFC_ASSERT(a_insert_grows, shift_en |=> region_count == $past(region_count) + 1'b1, "insert did not grow table")
  `RTFC_ASSERT(a_stall_holds, rsp_valid && rsp_stall |=> rsp_valid && $stable(region_count), "stalled result lost")
  `RTFC_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && region_count == '0, "reset left state")

endmodule

`default_nettype wire
